// ===== rtl/iss_pkg.sv =====
// Package for the intersection signal sequencer: types, codes, constants and helpers.
// It depends on nothing and is used by the interfaces, the register file and the top level.
package iss_pkg;

  localparam int unsigned TimeW   = 10;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned LampW   = 2;
  localparam int unsigned SignW   = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef logic [TimeW-1:0] ticks_t;

  typedef enum logic [PhaseW-1:0] {
    PH_NS_ALL_RED = 4'd0,
    PH_NS_LEFT    = 4'd1,
    PH_NS_GREEN   = 4'd2,
    PH_NS_FLASH   = 4'd3,
    PH_NS_YELLOW  = 4'd4,
    PH_EW_ALL_RED = 4'd5,
    PH_EW_GREEN   = 4'd6,
    PH_EW_WALK    = 4'd7,
    PH_EW_FLASH   = 4'd8,
    PH_EW_YELLOW  = 4'd9
  } phase_e;

  typedef enum logic [LampW-1:0] {
    LAMP_RED    = 2'd0,
    LAMP_YELLOW = 2'd1,
    LAMP_GREEN  = 2'd2
  } lamp_e;

  typedef enum logic [SignW-1:0] {
    SIGN_DONT  = 2'd0,
    SIGN_WALK  = 2'd1,
    SIGN_BLANK = 2'd2
  } sign_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GREEN_NS  = 3'd0,
    CFG_GREEN_EW  = 3'd1,
    CFG_FLASH_NS  = 3'd2,
    CFG_FLASH_EW  = 3'd3,
    CFG_YELLOW_NS = 3'd4,
    CFG_YELLOW_EW = 3'd5,
    CFG_ALL_RED   = 3'd6,
    CFG_LEFT      = 3'd7
  } cfg_idx_e;

  localparam ticks_t GreenNsReset  = 10'd100;
  localparam ticks_t GreenEwReset  = 10'd100;
  localparam ticks_t FlashNsReset  = 10'd30;
  localparam ticks_t FlashEwReset  = 10'd30;
  localparam ticks_t YellowNsReset = 10'd30;
  localparam ticks_t YellowEwReset = 10'd30;
  localparam ticks_t AllRedReset   = 10'd20;
  localparam ticks_t LeftReset     = 10'd40;

  typedef struct packed {
    ticks_t green_ns_time;
    ticks_t green_ew_time;
    ticks_t flash_ns_time;
    ticks_t flash_ew_time;
    ticks_t yellow_ns_time;
    ticks_t yellow_ew_time;
    ticks_t all_red_time;
    ticks_t left_arrow_time;
  } cfg_t;

  typedef struct packed {
    logic car_waiting;
    logic walk_press;
    logic flash_pulse;
  } tick_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase_now;
    logic [LampW-1:0]  ns_lamp;
    logic              ns_left_arrow;
    logic [LampW-1:0]  ew_lamp;
    logic [SignW-1:0]  ns_sign;
    logic [SignW-1:0]  ew_sign;
    logic              walk_waiting;
  } result_t;

  function automatic ticks_t sub_sat(ticks_t a, ticks_t b);
    return (a > b) ? ticks_t'(a - b) : '0;
  endfunction

endpackage

// ===== rtl/iss_tick_if.sv =====
// Handshake channel that carries one tick transaction into the sequencer.
// It depends on iss_pkg for the payload type.
interface iss_tick_if import iss_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/iss_result_if.sv =====
// Handshake channel that carries one result transaction out of the sequencer.
// It depends on iss_pkg for the payload type.
interface iss_result_if import iss_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/intersection_signal_sequencer.sv =====
// Top level of the intersection signal sequencer: ten-phase state machine and result register.
// It depends on iss_pkg, iss_tick_if, iss_result_if and iss_cfg_regs.
// The result is registered: an accepted tick transaction gives its result in the next cycle.
// Throughput: one tick per cycle unless the output stalls; the phase update is combinational.
// The input is held off only while a result waits and the receiver stalls it.
// Reset puts the sequencer in north-south all-red with default durations and no result pending.
module intersection_signal_sequencer import iss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  ticks_t              cfg_data_i,
  iss_tick_if.sink            tick_i,
  iss_result_if.source        result_o
);

  cfg_t    cfg;
  logic    tick_fire;

  phase_e  phase_q, phase_d;
  ticks_t  elapsed_q, elapsed_d, elapsed_inc;
  ticks_t  hold_q, hold_d;
  logic    entered_q, entered_d;
  logic    left_served_q, left_served_d;
  logic    walk_latch_q, walk_latch_d;
  logic    ns_flash_q, ns_flash_d;
  logic    ew_flash_q, ew_flash_d;
  sign_e   ns_sign_q, ns_sign_d;
  sign_e   ew_sign_q, ew_sign_d;
  lamp_e   ns_lamp, ew_lamp;
  logic    arrow;
  logic    done;
  ticks_t  ns_green_hold;

  result_t res_q, res_d;
  logic    res_valid_q;

  iss_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign tick_i.ready = !res_valid_q || result_o.ready;
  assign tick_fire    = tick_i.valid && tick_i.ready;

  assign elapsed_inc = (elapsed_q != TimeMax) ? ticks_t'(elapsed_q + 1'b1) : elapsed_q;
  assign ns_green_hold = sub_sat(
      left_served_q ? sub_sat(cfg.green_ns_time, cfg.left_arrow_time) : cfg.green_ns_time,
      cfg.flash_ns_time);

  always_comb begin
    phase_d       = phase_q;
    elapsed_d     = elapsed_inc;
    hold_d        = hold_q;
    entered_d     = entered_q;
    left_served_d = left_served_q;
    walk_latch_d  = walk_latch_q;
    ns_flash_d    = ns_flash_q;
    ew_flash_d    = ew_flash_q;
    ns_sign_d     = ns_sign_q;
    ew_sign_d     = ew_sign_q;
    ns_lamp       = LAMP_RED;
    ew_lamp       = LAMP_RED;
    arrow         = 1'b0;

    if (!entered_q) begin
      entered_d = 1'b1;
      ns_sign_d = SIGN_DONT;
      ew_sign_d = SIGN_DONT;
      unique case (phase_q)
        PH_NS_LEFT:    hold_d = cfg.left_arrow_time;
        PH_NS_GREEN: begin
          hold_d        = ns_green_hold;
          left_served_d = 1'b0;
          ns_sign_d     = SIGN_WALK;
        end
        PH_NS_FLASH:   hold_d = cfg.flash_ns_time;
        PH_NS_YELLOW:  hold_d = cfg.yellow_ns_time;
        PH_EW_ALL_RED: hold_d = cfg.all_red_time;
        PH_EW_GREEN:   hold_d = cfg.green_ew_time;
        PH_EW_WALK: begin
          hold_d       = sub_sat(cfg.green_ew_time, cfg.flash_ew_time);
          ew_sign_d    = SIGN_WALK;
          walk_latch_d = 1'b0;
        end
        PH_EW_FLASH:   hold_d = cfg.flash_ew_time;
        PH_EW_YELLOW:  hold_d = cfg.yellow_ew_time;
        default: ;
      endcase
    end

    if (phase_q == PH_NS_FLASH && tick_i.data.flash_pulse) begin
      ns_sign_d  = ns_flash_q ? SIGN_DONT : SIGN_BLANK;
      ns_flash_d = !ns_flash_q;
    end
    if (phase_q == PH_EW_FLASH && tick_i.data.flash_pulse) begin
      ew_sign_d  = ew_flash_q ? SIGN_DONT : SIGN_BLANK;
      ew_flash_d = !ew_flash_q;
    end

    unique case (phase_q)
      PH_NS_LEFT:                          arrow   = 1'b1;
      PH_NS_GREEN, PH_NS_FLASH:            ns_lamp = LAMP_GREEN;
      PH_NS_YELLOW:                        ns_lamp = LAMP_YELLOW;
      PH_EW_GREEN, PH_EW_WALK, PH_EW_FLASH: ew_lamp = LAMP_GREEN;
      PH_EW_YELLOW:                        ew_lamp = LAMP_YELLOW;
      default: ;
    endcase

    if (phase_q == PH_NS_ALL_RED) begin
      done = elapsed_inc >= cfg.all_red_time;
    end else begin
      done = elapsed_inc >= hold_d;
    end

    if (done) begin
      entered_d = 1'b0;
      elapsed_d = '0;
      unique case (phase_q)
        PH_NS_ALL_RED: begin
          if (tick_i.data.car_waiting) begin
            left_served_d = 1'b1;
            phase_d       = PH_NS_LEFT;
          end else begin
            phase_d = PH_NS_GREEN;
          end
        end
        PH_NS_LEFT:    phase_d = PH_NS_GREEN;
        PH_NS_GREEN:   phase_d = PH_NS_FLASH;
        PH_NS_FLASH:   phase_d = PH_NS_YELLOW;
        PH_NS_YELLOW:  phase_d = PH_EW_ALL_RED;
        PH_EW_ALL_RED: phase_d = walk_latch_d ? PH_EW_WALK : PH_EW_GREEN;
        PH_EW_GREEN:   phase_d = PH_EW_YELLOW;
        PH_EW_WALK:    phase_d = PH_EW_FLASH;
        PH_EW_FLASH:   phase_d = PH_EW_YELLOW;
        PH_EW_YELLOW:  phase_d = PH_NS_ALL_RED;
        default:       phase_d = PH_NS_GREEN;
      endcase
    end

    if (tick_i.data.walk_press) begin
      walk_latch_d = 1'b1;
    end

    res_d.phase_now     = phase_q;
    res_d.ns_lamp       = ns_lamp;
    res_d.ns_left_arrow = arrow;
    res_d.ew_lamp       = ew_lamp;
    res_d.ns_sign       = ns_sign_d;
    res_d.ew_sign       = ew_sign_d;
    res_d.walk_waiting  = walk_latch_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_NS_ALL_RED;
      elapsed_q     <= '0;
      hold_q        <= '0;
      entered_q     <= 1'b0;
      left_served_q <= 1'b0;
      walk_latch_q  <= 1'b0;
      ns_flash_q    <= 1'b0;
      ew_flash_q    <= 1'b0;
      ns_sign_q     <= SIGN_DONT;
      ew_sign_q     <= SIGN_DONT;
    end else if (tick_fire) begin
      phase_q       <= phase_d;
      elapsed_q     <= elapsed_d;
      hold_q        <= hold_d;
      entered_q     <= entered_d;
      left_served_q <= left_served_d;
      walk_latch_q  <= walk_latch_d;
      ns_flash_q    <= ns_flash_d;
      ew_flash_q    <= ew_flash_d;
      ns_sign_q     <= ns_sign_d;
      ew_sign_q     <= ew_sign_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (tick_fire) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_fire) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid = res_valid_q;
  assign result_o.data  = res_q;

endmodule

// ===== rtl/iss_cfg_regs.sv =====
// Configuration register file of the sequencer: eight phase durations in ticks.
// It depends on iss_pkg for the register indexes, reset values and cfg_t.
module iss_cfg_regs import iss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  ticks_t             cfg_data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.green_ns_time   <= GreenNsReset;
      cfg_q.green_ew_time   <= GreenEwReset;
      cfg_q.flash_ns_time   <= FlashNsReset;
      cfg_q.flash_ew_time   <= FlashEwReset;
      cfg_q.yellow_ns_time  <= YellowNsReset;
      cfg_q.yellow_ew_time  <= YellowEwReset;
      cfg_q.all_red_time    <= AllRedReset;
      cfg_q.left_arrow_time <= LeftReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GREEN_NS:  cfg_q.green_ns_time   <= cfg_data_i;
        CFG_GREEN_EW:  cfg_q.green_ew_time   <= cfg_data_i;
        CFG_FLASH_NS:  cfg_q.flash_ns_time   <= cfg_data_i;
        CFG_FLASH_EW:  cfg_q.flash_ew_time   <= cfg_data_i;
        CFG_YELLOW_NS: cfg_q.yellow_ns_time  <= cfg_data_i;
        CFG_YELLOW_EW: cfg_q.yellow_ew_time  <= cfg_data_i;
        CFG_ALL_RED:   cfg_q.all_red_time    <= cfg_data_i;
        CFG_LEFT:      cfg_q.left_arrow_time <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== dv/intersection_signal_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the intersection signal sequencer: tick transactions in, lamp
// and sign results out, each compared with a cycle-free model of the phase machine kept here.
// It depends on iss_pkg, iss_tick_if, iss_result_if and the sequencer RTL.
module intersection_signal_sequencer_tb;
  import iss_pkg::*;

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_e;

  logic   clk_i = 1'b0;
  logic   rst_ni;
  logic   cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  ticks_t cfg_data_i;

  iss_tick_if   tick_if ();
  iss_result_if result_if ();

  intersection_signal_sequencer u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tick_i     (tick_if),
    .result_o   (result_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Timing registers and phase state as the sequencer should hold them.
  ticks_t  timing_cfg [8];
  phase_e  cur_phase;
  ticks_t  tick_count;
  ticks_t  hold_len;
  logic    entry_done;
  logic    left_pending;
  logic    ped_request;
  logic    ns_blink;
  logic    ew_blink;
  sign_e   ns_sign_q;
  sign_e   ew_sign_q;

  result_t expected_lamps [$];
  int      error_count;
  int      send_idle_pct;
  int      stall_pct;
  int      stall_request;
  int      stall_left;
  int      idle_rotation;

  task automatic reset_sequencer_model();
    timing_cfg[CFG_GREEN_NS]  = GreenNsReset;
    timing_cfg[CFG_GREEN_EW]  = GreenEwReset;
    timing_cfg[CFG_FLASH_NS]  = FlashNsReset;
    timing_cfg[CFG_FLASH_EW]  = FlashEwReset;
    timing_cfg[CFG_YELLOW_NS] = YellowNsReset;
    timing_cfg[CFG_YELLOW_EW] = YellowEwReset;
    timing_cfg[CFG_ALL_RED]   = AllRedReset;
    timing_cfg[CFG_LEFT]      = LeftReset;
    cur_phase    = PH_NS_ALL_RED;
    tick_count   = '0;
    hold_len     = '0;
    entry_done   = 1'b0;
    left_pending = 1'b0;
    ped_request  = 1'b0;
    ns_blink     = 1'b0;
    ew_blink     = 1'b0;
    ns_sign_q    = SIGN_DONT;
    ew_sign_q    = SIGN_DONT;
  endtask

  function automatic result_t advance_sequencer(tick_t t);
    phase_e  cur;
    phase_e  nxt;
    lamp_e   ns_lamp;
    lamp_e   ew_lamp;
    logic    arrow;
    logic    finished;
    result_t r;
    cur     = cur_phase;
    nxt     = cur;
    ns_lamp = LAMP_RED;
    ew_lamp = LAMP_RED;
    arrow   = 1'b0;
    if (tick_count != TimeMax) tick_count = tick_count + 1'b1;

    if (!entry_done) begin
      entry_done = 1'b1;
      ns_sign_q  = SIGN_DONT;
      ew_sign_q  = SIGN_DONT;
      case (cur)
        PH_NS_LEFT: hold_len = timing_cfg[CFG_LEFT];
        PH_NS_GREEN: begin
          hold_len = timing_cfg[CFG_GREEN_NS];
          if (left_pending) begin
            hold_len = (hold_len > timing_cfg[CFG_LEFT]) ?
                       ticks_t'(hold_len - timing_cfg[CFG_LEFT]) : '0;
            left_pending = 1'b0;
          end
          hold_len = (hold_len > timing_cfg[CFG_FLASH_NS]) ?
                     ticks_t'(hold_len - timing_cfg[CFG_FLASH_NS]) : '0;
          ns_sign_q = SIGN_WALK;
        end
        PH_NS_FLASH:   hold_len = timing_cfg[CFG_FLASH_NS];
        PH_NS_YELLOW:  hold_len = timing_cfg[CFG_YELLOW_NS];
        PH_EW_ALL_RED: hold_len = timing_cfg[CFG_ALL_RED];
        PH_EW_GREEN:   hold_len = timing_cfg[CFG_GREEN_EW];
        PH_EW_WALK: begin
          hold_len = (timing_cfg[CFG_GREEN_EW] > timing_cfg[CFG_FLASH_EW]) ?
                     ticks_t'(timing_cfg[CFG_GREEN_EW] - timing_cfg[CFG_FLASH_EW]) : '0;
          ew_sign_q   = SIGN_WALK;
          ped_request = 1'b0;
        end
        PH_EW_FLASH:   hold_len = timing_cfg[CFG_FLASH_EW];
        PH_EW_YELLOW:  hold_len = timing_cfg[CFG_YELLOW_EW];
        default: ;
      endcase
    end

    if (cur == PH_NS_FLASH && t.flash_pulse) begin
      ns_sign_q = ns_blink ? SIGN_DONT : SIGN_BLANK;
      ns_blink  = ~ns_blink;
    end
    if (cur == PH_EW_FLASH && t.flash_pulse) begin
      ew_sign_q = ew_blink ? SIGN_DONT : SIGN_BLANK;
      ew_blink  = ~ew_blink;
    end

    case (cur)
      PH_NS_LEFT:                         arrow   = 1'b1;
      PH_NS_GREEN, PH_NS_FLASH:           ns_lamp = LAMP_GREEN;
      PH_NS_YELLOW:                       ns_lamp = LAMP_YELLOW;
      PH_EW_GREEN, PH_EW_WALK, PH_EW_FLASH: ew_lamp = LAMP_GREEN;
      PH_EW_YELLOW:                       ew_lamp = LAMP_YELLOW;
      default: ;
    endcase

    // North-south all-red compares against the register itself on every tick.
    if (cur == PH_NS_ALL_RED) finished = (tick_count >= timing_cfg[CFG_ALL_RED]);
    else finished = (tick_count >= hold_len);

    if (finished) begin
      entry_done = 1'b0;
      tick_count = '0;
      case (cur)
        PH_NS_ALL_RED: begin
          if (t.car_waiting) begin
            left_pending = 1'b1;
            nxt = PH_NS_LEFT;
          end else begin
            nxt = PH_NS_GREEN;
          end
        end
        PH_EW_ALL_RED: nxt = ped_request ? PH_EW_WALK : PH_EW_GREEN;
        PH_EW_GREEN:   nxt = PH_EW_YELLOW;
        PH_EW_YELLOW:  nxt = PH_NS_ALL_RED;
        default:       nxt = phase_e'(cur + 1'b1);
      endcase
    end
    cur_phase = nxt;
    if (t.walk_press) ped_request = 1'b1;

    r.phase_now     = cur;
    r.ns_lamp       = ns_lamp;
    r.ns_left_arrow = arrow;
    r.ew_lamp       = ew_lamp;
    r.ns_sign       = ns_sign_q;
    r.ew_sign       = ew_sign_q;
    r.walk_waiting  = ped_request;
    return r;
  endfunction

  task automatic compare_field(string field, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t exp_r;
    result_t act_r;
    if (rst_ni && result_if.valid && result_if.ready) begin
      act_r = result_if.data;
      if (expected_lamps.size() == 0) begin
        $display("%0t: unexpected result transaction, expected none, actual %h",
                 $time, act_r);
        error_count++;
      end else begin
        exp_r = expected_lamps.pop_front();
        compare_field("phase_now", exp_r.phase_now, act_r.phase_now);
        compare_field("ns_lamp", exp_r.ns_lamp, act_r.ns_lamp);
        compare_field("ns_left_arrow", exp_r.ns_left_arrow, act_r.ns_left_arrow);
        compare_field("ew_lamp", exp_r.ew_lamp, act_r.ew_lamp);
        compare_field("ns_sign", exp_r.ns_sign, act_r.ns_sign);
        compare_field("ew_sign", exp_r.ew_sign, act_r.ew_sign);
        compare_field("walk_waiting", exp_r.walk_waiting, act_r.walk_waiting);
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (stall_request > 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct = 57;
        stall_pct     = 0;
      end
      IDLE_RECV: begin
        send_idle_pct = 0;
        stall_pct     = 57;
      end
      IDLE_BOTH: begin
        send_idle_pct = 36;
        stall_pct     = 36;
      end
      default: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
    endcase
  endtask

  task automatic send_tick(tick_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick_if.valid <= 1'b1;
    tick_if.data  <= t;
    do @(posedge clk_i); while (!tick_if.ready);
    expected_lamps.push_back(advance_sequencer(t));
  endtask

  task automatic wait_drain();
    tick_if.valid <= 1'b0;
    while (expected_lamps.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_config(cfg_t c);
    ticks_t vals [8];
    vals[CFG_GREEN_NS]  = c.green_ns_time;
    vals[CFG_GREEN_EW]  = c.green_ew_time;
    vals[CFG_FLASH_NS]  = c.flash_ns_time;
    vals[CFG_FLASH_EW]  = c.flash_ew_time;
    vals[CFG_YELLOW_NS] = c.yellow_ns_time;
    vals[CFG_YELLOW_EW] = c.yellow_ew_time;
    vals[CFG_ALL_RED]   = c.all_red_time;
    vals[CFG_LEFT]      = c.left_arrow_time;
    for (int i = 0; i <= int'(CFG_LEFT); i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      timing_cfg[i] = vals[i];
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic ticks_t rand_duration();
    if ($urandom_range(0, 9) == 0) return '0;
    return ticks_t'($urandom_range(1, 12));
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    t.car_waiting = 1'($urandom_range(0, 1));
    t.walk_press  = ($urandom_range(0, 4) == 0);
    t.flash_pulse = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        set_idling(idle_mode_e'(idle_rotation % 4));
        idle_rotation++;
      end
      send_tick(rand_tick());
    end
  endtask

  task automatic test_reset_timing();
    set_idling(IDLE_NONE);
    for (int i = 0; i < 140; i++) send_tick(rand_tick());
  endtask

  task automatic test_directed_walkthrough();
    cfg_t c;
    wait_drain();
    c = '0;
    write_config(c);
    // Every phase lasts one tick: left arrow, walk entry with a fresh press, flash toggles.
    send_tick('{car_waiting: 1'b1, walk_press: 1'b0, flash_pulse: 1'b0});
    send_tick('{car_waiting: 1'b0, walk_press: 1'b1, flash_pulse: 1'b0});
    send_tick('{car_waiting: 1'b0, walk_press: 1'b0, flash_pulse: 1'b1});
    send_tick('{car_waiting: 1'b0, walk_press: 1'b0, flash_pulse: 1'b1});
    send_tick('{car_waiting: 1'b1, walk_press: 1'b0, flash_pulse: 1'b0});
    send_tick('{car_waiting: 1'b0, walk_press: 1'b0, flash_pulse: 1'b0});
    send_tick('{car_waiting: 1'b0, walk_press: 1'b1, flash_pulse: 1'b1});
    send_tick('{car_waiting: 1'b0, walk_press: 1'b0, flash_pulse: 1'b1});
    send_tick('{car_waiting: 1'b1, walk_press: 1'b0, flash_pulse: 1'b0});
    send_tick('{car_waiting: 1'b0, walk_press: 1'b0, flash_pulse: 1'b0});
    send_tick('{car_waiting: 1'b1, walk_press: 1'b1, flash_pulse: 1'b1});
    send_tick('{car_waiting: 1'b1, walk_press: 1'b1, flash_pulse: 1'b1});
    wait_drain();
    // Left and flash times larger than the greens, so both holds saturate at zero.
    c.green_ns_time   = 10'd3;
    c.left_arrow_time = 10'd7;
    c.flash_ns_time   = 10'd1;
    c.green_ew_time   = 10'd2;
    c.flash_ew_time   = 10'd9;
    c.all_red_time    = 10'd1;
    c.yellow_ns_time  = 10'd1;
    c.yellow_ew_time  = 10'd0;
    write_config(c);
    for (int i = 0; i < 13; i++) send_tick(tick_t'(3'(i * 5 + 1)));
  endtask

  task automatic test_random_timings();
    cfg_t c;
    for (int k = 0; k < 12; k++) begin
      wait_drain();
      if (k == 0) begin
        c = '1;
      end else if (k == 1) begin
        c = '0;
      end else begin
        c.green_ns_time   = rand_duration();
        c.green_ew_time   = rand_duration();
        c.flash_ns_time   = rand_duration();
        c.flash_ew_time   = rand_duration();
        c.yellow_ns_time  = rand_duration();
        c.yellow_ew_time  = rand_duration();
        c.all_red_time    = rand_duration();
        c.left_arrow_time = rand_duration();
      end
      write_config(c);
      run_random((k == 0) ? 20 : 60);
    end
  endtask

  task automatic test_output_backpressure();
    set_idling(IDLE_NONE);
    stall_request = 60;
    for (int i = 0; i < 80; i++) send_tick(rand_tick());
  endtask

  task automatic test_sender_pause();
    run_random(30);
    wait_drain();
    run_random(30);
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_GREEN_NS;
    cfg_data_i      = '0;
    tick_if.valid   = 1'b0;
    tick_if.data    = '0;
    result_if.ready = 1'b0;
    error_count     = 0;
    send_idle_pct   = 0;
    stall_pct       = 0;
    stall_request   = 0;
    stall_left      = 0;
    idle_rotation   = 0;
    reset_sequencer_model();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_timing();
    test_directed_walkthrough();
    test_random_timings();
    test_output_backpressure();
    test_sender_pause();

    wait_drain();
    set_idling(IDLE_NONE);
    repeat (5) @(posedge clk_i);
    if (expected_lamps.size() != 0) begin
      $display("%0t: results missing, expected %0d more, actual 0",
               $time, expected_lamps.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
